@@ hw/rtl/tcpu_pkg.sv @@
// Package for the tiny fetch/execute CPU: widths, command and opcode codes,
// stop causes and the sequencer state type.
// No dependencies.
package tcpu_pkg;

	localparam int unsigned DW            = 16;
	localparam int unsigned CW            = $clog2(DW);
	localparam int unsigned REG_COUNT     = 8;
	localparam int unsigned RW            = $clog2(REG_COUNT);
	localparam int unsigned AIW           = 10;
	localparam int unsigned PCW           = 10;
	localparam int unsigned MEM_WORDS_DEF = 1024;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_STEP    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_READ    = 2'd3;

	localparam logic [5:0] OP_ADD   = 6'd0;
	localparam logic [5:0] OP_SUB   = 6'd1;
	localparam logic [5:0] OP_MUL   = 6'd2;
	localparam logic [5:0] OP_DIV   = 6'd3;
	localparam logic [5:0] OP_EQ    = 6'd4;
	localparam logic [5:0] OP_NE    = 6'd5;
	localparam logic [5:0] OP_LOAD  = 6'd15;
	localparam logic [5:0] OP_STORE = 6'd16;
	localparam logic [5:0] OP_HALTZ = 6'd63;

	localparam logic [1:0] IOP_JMP  = 2'd0;
	localparam logic [1:0] IOP_JEQ1 = 2'd1;
	localparam logic [1:0] IOP_HALT = 2'd2;
	localparam logic [1:0] IOP_MOVI = 2'd3;

	localparam logic [1:0] STOP_NONE  = 2'd0;
	localparam logic [1:0] STOP_HALT  = 2'd1;
	localparam logic [1:0] STOP_DIV0  = 2'd2;
	localparam logic [1:0] STOP_BADOP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MWR,
		S_MRD,
		S_RESTART,
		S_FETCH,
		S_DECODE,
		S_EXEC,
		S_DIV,
		S_WRAP,
		S_LDA,
		S_LDWB,
		S_ST,
		S_JMP,
		S_RESP
	} state_t;

endpackage

@@ hw/rtl/tiny_cpu_fetch_execute.sv @@
// Top level of the tiny fetch/execute CPU: word memory, register file,
// sequencer and iterative divider. Depends on tcpu_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | to block  | in_valid / in_stall | cmd, mem_addr, mem_data
//  out     | from block| out_valid/out_stall | pc_now, running, stop_cause, read_word
//
// A step while stopped goes straight to the response. Divide uses the radix-2 divider,
// which retires one quotient bit per clock. When MEM_WORDS is not a power of two each
// memory, jump, load or store address is first reduced in the wrap state.
// arst_n clears the sequencer, pc, flags and register valid bits; main memory is
// undefined until written and gets no clearing pass.
// A new transaction is taken while a result waits on out_stall; it completes once
// the output register is free.
module tiny_cpu_fetch_execute #(
	parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic [tcpu_pkg::AIW-1:0] mem_addr,
	input  logic [tcpu_pkg::DW-1:0]  mem_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [tcpu_pkg::PCW-1:0] pc_now,
	output logic                     running,
	output logic [1:0]               stop_cause,
	output logic [tcpu_pkg::DW-1:0]  read_word
);
	import tcpu_pkg::*;

	localparam int unsigned     AW        = $clog2(MEM_WORDS);
	localparam bit              NEED_WRAP = (MEM_WORDS & (MEM_WORDS - 1)) != 0;
	localparam int unsigned     WSH       = DW + AW;
	localparam longint unsigned WMUL      =
		((64'd1 << WSH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);

	state_t          state_q, state_nx, ret_q, wrap_tgt;
	logic [AW-1:0]   pc_q, pc_inc, pc_wd;
	logic            active_q;
	logic [1:0]      cause_q;
	logic            out_valid_q;
	logic [1:0]      cmd_q;
	logic [DW-1:0]   data_q, addr_q, ins_q, addr_src;
	logic [AW-1:0]   addr_w;
	logic            in_acc;

	logic [DW-1:0]   main_mem [MEM_WORDS];
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_wa, mem_ra;
	logic [DW-1:0]   mem_wd, mem_rdata_q;

	logic [DW-1:0]   rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic            rf_we, rf_re, rf_clr;
	logic [RW-1:0]   rf_wa, rf_ra1, rf_ra2;
	logic [DW-1:0]   rf_wd, rf_a_q, rf_b_q;

	logic            pc_we, stop_en, out_load, addr_go, div_go;
	logic [1:0]      stop_code;

	logic [DW-1:0]   quo_q, quo_nx;
	logic [DW:0]     rem_q, rem_nx, dvs_q;
	logic [DW+1:0]   trial;
	logic [CW-1:0]   cnt_q;
	logic            dv_last, wrap_done;

	logic [2*DW:0]   wprod;
	logic [DW-1:0]   wq_q, wq_nx, wrem;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign addr_w    = addr_q[AW-1:0];
	assign pc_inc    = (pc_q == AW'(MEM_WORDS - 1)) ? '0 : pc_q + AW'(1);

	assign trial   = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};
	assign dv_last = (cnt_q == CW'(DW - 1));

	assign wprod     = (2*DW+1)'(addr_q) * (2*DW+1)'(WMUL);
	assign wq_nx     = DW'(wprod >> WSH);
	assign wrem      = addr_q - wq_q * DW'(MEM_WORDS);
	assign wrap_done = (cnt_q == CW'(1));

	always_comb begin
		if (!trial[DW+1]) begin
			rem_nx = trial[DW:0];
			quo_nx = {quo_q[DW-2:0], 1'b1};
		end else begin
			rem_nx = {rem_q[DW-1:0], quo_q[DW-1]};
			quo_nx = {quo_q[DW-2:0], 1'b0};
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wa    = addr_w;
		mem_ra    = addr_w;
		mem_wd    = data_q;
		rf_re     = 1'b0;
		rf_ra1    = mem_rdata_q[5:3];
		rf_ra2    = mem_rdata_q[2:0];
		rf_we     = 1'b0;
		rf_wa     = ins_q[8:6];
		rf_wd     = '0;
		rf_clr    = 1'b0;
		pc_we     = 1'b0;
		pc_wd     = pc_inc;
		stop_en   = 1'b0;
		stop_code = STOP_NONE;
		addr_go   = 1'b0;
		addr_src  = 16'(mem_addr);
		wrap_tgt  = S_RESP;
		div_go    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
					addr_go  = 1'b1;
					wrap_tgt = (cmd == CMD_WRITE) ? S_MWR : S_MRD;
				end
			end
			S_MWR: mem_we = 1'b1;
			S_MRD: mem_re = 1'b1;
			S_RESTART: rf_clr = 1'b1;
			S_FETCH: begin
				mem_re = 1'b1;
				mem_ra = pc_q;
				pc_we  = 1'b1;
			end
			S_DECODE: begin
				rf_re = 1'b1;
				if (mem_rdata_q[15]) begin
					rf_ra1 = mem_rdata_q[12:10];
				end
			end
			S_EXEC: begin
				if (ins_q[15]) begin
					case (ins_q[14:13])
						IOP_JMP: begin
							addr_go  = 1'b1;
							addr_src = 16'(ins_q[9:0]);
							wrap_tgt = S_JMP;
						end
						IOP_JEQ1: begin
							addr_go  = (rf_a_q == 16'd1);
							addr_src = 16'(ins_q[9:0]);
							wrap_tgt = S_JMP;
						end
						IOP_HALT: begin
							stop_en   = 1'b1;
							stop_code = STOP_HALT;
						end
						IOP_MOVI: begin
							rf_we = 1'b1;
							rf_wa = ins_q[12:10];
							rf_wd = 16'(ins_q[9:0]);
						end
						default: rf_we = 1'b0;
					endcase
				end else begin
					case (ins_q[14:9])
						OP_ADD: begin
							rf_we = 1'b1;
							rf_wd = rf_a_q + rf_b_q;
						end
						OP_SUB: begin
							rf_we = 1'b1;
							rf_wd = rf_a_q - rf_b_q;
						end
						OP_MUL: begin
							rf_we = 1'b1;
							rf_wd = rf_a_q * rf_b_q;
						end
						OP_DIV: begin
							if (rf_b_q == '0) begin
								stop_en   = 1'b1;
								stop_code = STOP_DIV0;
							end else begin
								div_go = 1'b1;
							end
						end
						OP_EQ: begin
							rf_we = 1'b1;
							rf_wd = 16'(rf_a_q == rf_b_q);
						end
						OP_NE: begin
							rf_we = 1'b1;
							rf_wd = 16'(rf_a_q != rf_b_q);
						end
						OP_LOAD: begin
							addr_go  = 1'b1;
							addr_src = rf_a_q;
							wrap_tgt = S_LDA;
						end
						OP_STORE: begin
							addr_go  = 1'b1;
							addr_src = rf_a_q;
							wrap_tgt = S_ST;
						end
						OP_HALTZ: begin
							stop_en   = (rf_a_q == '0);
							stop_code = STOP_HALT;
						end
						default: begin
							stop_en   = 1'b1;
							stop_code = STOP_BADOP;
						end
					endcase
				end
			end
			S_DIV: begin
				if (dv_last) begin
					rf_we = 1'b1;
					rf_wd = quo_nx;
				end
			end
			S_LDA: mem_re = 1'b1;
			S_LDWB: begin
				rf_we = 1'b1;
				rf_wd = mem_rdata_q;
			end
			S_ST: begin
				mem_we = 1'b1;
				mem_wd = rf_b_q;
			end
			S_JMP: begin
				pc_we = 1'b1;
				pc_wd = addr_w;
			end
			S_RESP: out_load = !out_valid_q || !out_stall;
			default: out_load = 1'b0;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (cmd)
						CMD_RESTART: state_nx = S_RESTART;
						CMD_STEP:    state_nx = active_q ? S_FETCH : S_RESP;
						default:     state_nx = S_IDLE;
					endcase
				end
			end
			S_FETCH:  state_nx = S_DECODE;
			S_DECODE: state_nx = S_EXEC;
			S_EXEC:   state_nx = div_go ? S_DIV : S_RESP;
			S_DIV: begin
				if (dv_last) begin
					state_nx = S_RESP;
				end
			end
			S_WRAP: begin
				if (wrap_done) begin
					state_nx = ret_q;
				end
			end
			S_LDA: state_nx = S_LDWB;
			S_MWR, S_MRD, S_RESTART, S_LDWB, S_ST, S_JMP: state_nx = S_RESP;
			S_RESP: state_nx = out_load ? S_IDLE : S_RESP;
			default: state_nx = S_IDLE;
		endcase
		if (addr_go) begin
			state_nx = NEED_WRAP ? S_WRAP : wrap_tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_RESP;
			pc_q        <= '0;
			active_q    <= 1'b1;
			cause_q     <= STOP_NONE;
			out_valid_q <= 1'b0;
			rf_vld_q    <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (addr_go) begin
				ret_q <= wrap_tgt;
			end
			if (rf_clr) begin
				pc_q     <= '0;
				active_q <= 1'b1;
				cause_q  <= STOP_NONE;
				rf_vld_q <= '0;
			end else begin
				if (pc_we) begin
					pc_q <= pc_wd;
				end
				if (stop_en) begin
					active_q <= 1'b0;
					cause_q  <= stop_code;
				end
				if (rf_we) begin
					rf_vld_q[rf_wa] <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (addr_go || div_go) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV || state_q == S_WRAP) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= cmd;
			data_q <= mem_data;
		end
		if (state_q == S_DECODE) begin
			ins_q <= mem_rdata_q;
		end
		if (addr_go) begin
			addr_q <= addr_src;
		end else if (state_q == S_WRAP && wrap_done) begin
			addr_q <= wrem;
		end
		if (state_q == S_WRAP) begin
			wq_q <= wq_nx;
		end
		if (div_go) begin
			quo_q <= rf_a_q;
			rem_q <= '0;
			dvs_q <= {1'b0, rf_b_q};
		end else if (state_q == S_DIV) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
		if (out_load) begin
			pc_now     <= PCW'(pc_q);
			running    <= active_q;
			stop_cause <= cause_q;
			read_word  <= (cmd_q == CMD_READ) ? mem_rdata_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			main_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rdata_q <= main_mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_wa] <= rf_wd;
		end
		if (rf_re) begin
			rf_a_q <= rf_vld_q[rf_ra1] ? rf_mem[rf_ra1] : '0;
			rf_b_q <= rf_vld_q[rf_ra2] ? rf_mem[rf_ra2] : '0;
		end
	end

	a_stop_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running || stop_cause != STOP_NONE))
		else $error("stopped result without a cause");

	a_fetch_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> active_q)
		else $error("fetch while cpu stopped");

	a_div_runs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !dv_last) |=> state_q == S_DIV)
		else $error("divider left early");

	a_pc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		17'(pc_q) < 17'(MEM_WORDS))
		else $error("pc beyond memory");

endmodule

@@ dv/tiny_cpu_fetch_execute_tb.sv @@
// Self-checking testbench for tiny_cpu_fetch_execute: a directed program, then random
// programs and memory traffic, checked by an in-bench CPU predictor or fixed results.
// Depends on tcpu_pkg and the tiny_cpu_fetch_execute RTL.
module tiny_cpu_fetch_execute_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcpu_pkg::*;

	localparam int unsigned ITEMS       = 1600;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam logic [5:0]  OP_UNUSED   = 6'd6;

	typedef struct packed {
		logic [PCW-1:0] pc;
		logic           run;
		logic [1:0]     cause;
		logic [DW-1:0]  word;
	} cpu_result_t;

	typedef struct {
		logic [1:0]     cmd;
		logic [AIW-1:0] addr;
		logic [DW-1:0]  data;
		bit             typed;
		cpu_result_t    want;
	} dir_row_t;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_stall;
	logic [1:0]     cmd       = CMD_WRITE;
	logic [AIW-1:0] mem_addr  = '0;
	logic [DW-1:0]  mem_data  = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic [PCW-1:0] pc_now;
	logic           running;
	logic [1:0]     stop_cause;
	logic [DW-1:0]  read_word;

	logic [DW-1:0]  cpu_mem [MEM_WORDS_DEF];
	bit             mem_set [MEM_WORDS_DEF];
	int unsigned    set_list[$];
	logic [DW-1:0]  cpu_regs [REG_COUNT];
	logic [PCW-1:0] cpu_pc;
	logic           cpu_run;
	logic [1:0]     cpu_cause;

	cpu_result_t    pending_results[$];
	dir_row_t       dir_rows[$];
	int unsigned    sent  = 0;
	int unsigned    fails = 0;
	int unsigned    quiet_cycles = 0;
	bit             calm = 1'b0;

	tiny_cpu_fetch_execute DUT (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .mem_addr, .mem_data,
		.out_valid, .out_stall, .pc_now, .running, .stop_cause, .read_word
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [DW-1:0] r_word(logic [5:0] op, logic [2:0] d, logic [2:0] a,
			logic [2:0] b);
		return {1'b0, op, d, a, b};
	endfunction

	function automatic logic [DW-1:0] i_word(logic [1:0] op, logic [2:0] d, logic [9:0] imm);
		return {1'b1, op, d, imm};
	endfunction

	function automatic logic [DW-1:0] rand_instr();
		logic [5:0] op;
		logic [1:0] iop;
		logic [9:0] imm;
		int unsigned k;
		k = $urandom_range(99);
		if (k < 8)
			return 16'($urandom);
		if (k < 55) begin
			case ($urandom_range(9))
				0: op = OP_ADD;
				1: op = OP_SUB;
				2: op = OP_MUL;
				3: op = OP_DIV;
				4: op = OP_EQ;
				5: op = OP_NE;
				6: op = OP_LOAD;
				7: op = OP_STORE;
				8: op = OP_HALTZ;
				default: op = 6'($urandom);
			endcase
			return {1'b0, op, 9'($urandom)};
		end
		k = $urandom_range(99);
		iop = (k < 40) ? IOP_MOVI : (k < 60) ? IOP_JMP : (k < 88) ? IOP_JEQ1 : IOP_HALT;
		k = $urandom_range(99);
		imm = (k < 25) ? 10'($urandom) : (k < 60) ? 10'($urandom_range(3)) :
			10'($urandom_range(31));
		return {1'b1, iop, 3'($urandom), imm};
	endfunction

	function automatic void cpu_clear();
		foreach (cpu_regs[i])
			cpu_regs[i] = '0;
		cpu_pc    = '0;
		cpu_run   = 1'b1;
		cpu_cause = STOP_NONE;
	endfunction

	function automatic void mem_put(logic [AIW-1:0] a, logic [DW-1:0] d);
		cpu_mem[a] = d;
		if (!mem_set[a]) begin
			mem_set[a] = 1'b1;
			set_list.push_back(a);
		end
	endfunction

	function automatic cpu_result_t cpu_apply(logic [1:0] c, logic [AIW-1:0] a,
			logic [DW-1:0] d);
		cpu_result_t r;
		logic [DW-1:0] w, x, y;
		logic [2:0] rd;
		r.word = '0;
		case (c)
			CMD_WRITE: mem_put(a, d);
			CMD_STEP: begin
				if (cpu_run) begin
					w = cpu_mem[cpu_pc];
					cpu_pc = cpu_pc + 1'b1;
					if (w[15]) begin
						rd = w[12:10];
						case (w[14:13])
							IOP_JMP: cpu_pc = w[9:0];
							IOP_JEQ1: if (cpu_regs[rd] == 16'd1) cpu_pc = w[9:0];
							IOP_HALT: begin
								cpu_run   = 1'b0;
								cpu_cause = STOP_HALT;
							end
							default: cpu_regs[rd] = {6'd0, w[9:0]};
						endcase
					end else begin
						rd = w[8:6];
						x  = cpu_regs[w[5:3]];
						y  = cpu_regs[w[2:0]];
						case (w[14:9])
							OP_ADD: cpu_regs[rd] = x + y;
							OP_SUB: cpu_regs[rd] = x - y;
							OP_MUL: cpu_regs[rd] = x * y;
							OP_DIV: begin
								if (y == '0) begin
									cpu_run   = 1'b0;
									cpu_cause = STOP_DIV0;
								end else
									cpu_regs[rd] = x / y;
							end
							OP_EQ: cpu_regs[rd] = {15'd0, x == y};
							OP_NE: cpu_regs[rd] = {15'd0, x != y};
							OP_LOAD: cpu_regs[rd] = cpu_mem[x[AIW-1:0]];
							OP_STORE: mem_put(x[AIW-1:0], y);
							OP_HALTZ: begin
								if (x == '0) begin
									cpu_run   = 1'b0;
									cpu_cause = STOP_HALT;
								end
							end
							default: begin
								cpu_run   = 1'b0;
								cpu_cause = STOP_BADOP;
							end
						endcase
					end
				end
			end
			CMD_RESTART: cpu_clear();
			default: r.word = cpu_mem[a];
		endcase
		r.pc    = cpu_pc;
		r.run   = cpu_run;
		r.cause = cpu_cause;
		return r;
	endfunction

	function automatic void add_row(logic [1:0] c, logic [AIW-1:0] a, logic [DW-1:0] d,
			bit typed = 1'b0, logic [PCW-1:0] pc = '0, logic run = 1'b0,
			logic [1:0] cause = STOP_NONE);
		dir_row_t row;
		row.cmd   = c;
		row.addr  = a;
		row.data  = d;
		row.typed = typed;
		row.want  = '{pc, run, cause, 16'd0};
		dir_rows.push_back(row);
	endfunction

	function automatic void compare(string field, logic [DW-1:0] want, logic [DW-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
			fails++;
		end
	endfunction

	task automatic send(logic [1:0] c, logic [AIW-1:0] a, logic [DW-1:0] d,
			bit typed = 1'b0, cpu_result_t want = '0);
		cpu_result_t model;
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		mem_addr <= a;
		mem_data <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		model = cpu_apply(c, a, d);
		pending_results.push_back(typed ? want : model);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// make sure the fetched word, and a load's source word, have been written
	task automatic step_safe();
		logic [DW-1:0] w;
		logic [AIW-1:0] target;
		if (cpu_run) begin
			if (!mem_set[cpu_pc])
				send(CMD_WRITE, cpu_pc, rand_instr());
			w = cpu_mem[cpu_pc];
			target = cpu_regs[w[5:3]][AIW-1:0];
			if (!w[15] && w[14:9] == OP_LOAD && !mem_set[target])
				send(CMD_WRITE, target, 16'($urandom));
		end
		send(CMD_STEP, 10'($urandom), 16'($urandom));
	endtask

	always @(posedge clk) begin
		cpu_result_t got, want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (out_valid && !out_stall) begin
			got = '{pc_now, running, stop_cause, read_word};
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none expected, actual %h", $time, got);
				fails++;
			end else begin
				want = pending_results.pop_front();
				compare("pc_now", 16'(want.pc), 16'(got.pc));
				compare("running", 16'(want.run), 16'(got.run));
				compare("stop_cause", 16'(want.cause), 16'(got.cause));
				compare("read_word", want.word, got.word);
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 23);
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tiny_cpu_fetch_execute: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned pick, last_drain;
		logic [AIW-1:0] a;
		cpu_clear();

		add_row(CMD_WRITE, 10'd0, 16'hFFFF, 1'b1, 10'd0, 1'b1, STOP_NONE);
		add_row(CMD_WRITE, 10'd1, i_word(IOP_MOVI, 3'd1, 10'd1));
		add_row(CMD_WRITE, 10'd2, r_word(OP_ADD, 3'd2, 3'd7, 3'd1));
		add_row(CMD_WRITE, 10'd3, r_word(OP_SUB, 3'd3, 3'd0, 3'd1));
		add_row(CMD_WRITE, 10'd4, r_word(OP_MUL, 3'd4, 3'd3, 3'd3));
		add_row(CMD_WRITE, 10'd5, r_word(OP_DIV, 3'd5, 3'd3, 3'd2));
		add_row(CMD_WRITE, 10'd6, r_word(OP_EQ, 3'd6, 3'd4, 3'd1));
		add_row(CMD_WRITE, 10'd7, r_word(OP_NE, 3'd6, 3'd4, 3'd1));
		add_row(CMD_WRITE, 10'd8, r_word(OP_STORE, 3'd0, 3'd2, 3'd5));
		add_row(CMD_WRITE, 10'd9, r_word(OP_LOAD, 3'd0, 3'd7, 3'd0));
		add_row(CMD_WRITE, 10'd10, r_word(OP_HALTZ, 3'd0, 3'd1, 3'd0));
		add_row(CMD_WRITE, 10'd11, i_word(IOP_JEQ1, 3'd6, 10'd5));
		add_row(CMD_WRITE, 10'd12, i_word(IOP_JMP, 3'd0, 10'd1023));
		add_row(CMD_WRITE, 10'd1023, r_word(OP_UNUSED, 3'd7, 3'd7, 3'd7));
		repeat (13)
			add_row(CMD_STEP, 10'd0, 16'd0);
		add_row(CMD_STEP, 10'd0, 16'd0, 1'b1, 10'd0, 1'b0, STOP_BADOP);
		add_row(CMD_STEP, 10'd0, 16'd0, 1'b1, 10'd0, 1'b0, STOP_BADOP);
		add_row(CMD_READ, 10'd1023, 16'd0);
		add_row(CMD_RESTART, 10'd0, 16'd0, 1'b1, 10'd0, 1'b1, STOP_NONE);
		add_row(CMD_WRITE, 10'd0, r_word(OP_DIV, 3'd1, 3'd2, 3'd3), 1'b1, 10'd0, 1'b1,
			STOP_NONE);
		add_row(CMD_STEP, 10'd0, 16'd0, 1'b1, 10'd1, 1'b0, STOP_DIV0);
		add_row(CMD_RESTART, 10'd0, 16'd0, 1'b1, 10'd0, 1'b1, STOP_NONE);
		add_row(CMD_WRITE, 10'd0, i_word(IOP_HALT, 3'd0, 10'd0), 1'b1, 10'd0, 1'b1,
			STOP_NONE);
		add_row(CMD_STEP, 10'd0, 16'd0, 1'b1, 10'd1, 1'b0, STOP_HALT);

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].typed,
				dir_rows[i].want);
		drain();
		last_drain = sent;

		while (sent < ITEMS) begin
			calm = (sent >= 700 && sent < 1000);
			if (sent - last_drain >= 350) begin
				drain();
				last_drain = sent;
			end
			pick = $urandom_range(99);
			if (!cpu_run && pick < 50)
				send(CMD_RESTART, 10'($urandom), 16'($urandom));
			else if (pick < 60)
				step_safe();
			else if (pick < 78) begin
				a = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(31));
				send(CMD_WRITE, a, ($urandom_range(9) < 6) ? rand_instr() : 16'($urandom));
			end else if (pick < 92)
				send(CMD_READ, 10'(set_list[$urandom_range(set_list.size() - 1)]),
					16'($urandom));
			else
				send(CMD_RESTART, 10'($urandom), 16'($urandom));
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (fails == 0)
			$display("tiny_cpu_fetch_execute: match");
		else
			$display("tiny_cpu_fetch_execute: mismatch");
		$finish;
	end

endmodule
